// ===== rtl/clt_pkg.sv =====
// Shared types, constants and character classes for the command line tokenizer.
`default_nettype none
package clt_pkg;

    localparam int MAX_COMMANDS = 8;
    localparam int NAME_BYTES   = 64;
    localparam int ARG_BYTES    = 256;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_ARG  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_LINE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;
    localparam logic [1:0] ST_TOO_BIG  = 2'd3;

    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TOKEN = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] cmd_index;
        logic [7:0] position;
        logic [7:0] out_char;
        logic [1:0] status;
        logic       last;
    } result_t;

    // One queue entry carries every result of one accepted byte.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    function automatic logic is_lead_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

    function automatic result_t make_result(input logic [1:0] kind,
                                            input logic [3:0] idx,
                                            input logic [7:0] pos,
                                            input logic [7:0] chr,
                                            input logic [1:0] st);
        result_t r;
        r.kind      = kind;
        r.cmd_index = idx;
        r.position  = pos;
        r.out_char  = chr;
        r.status    = st;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/clt_front.sv =====
// Front end: scans each byte, updates the token state and builds its results.
`default_nettype none
module clt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire clt_pkg::item_t  item,
    output logic                 push,
    output clt_pkg::entry_t      entry
);
    import clt_pkg::*;

    logic [3:0] cnt_reg, cnt_next;
    phase_t     phase_reg, phase_next;
    logic       inargs_reg, inargs_next;
    logic [6:0] name_reg, name_next;
    logic [8:0] argl_reg, argl_next;
    logic [8:0] tok_reg, tok_next;
    logic       seen_reg, seen_next;
    logic [1:0] err_reg, err_next;

    logic [8:0] argl_commit;
    logic [8:0] argl_close;
    logic [8:0] arg_base;
    logic [9:0] arg_need;
    logic [7:0] name_need;
    logic [3:0] cnt_after;
    logic [1:0] line_status;
    result_t    r0, r1;
    logic       have0, have1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            phase_reg  <= PH_START;
            inargs_reg <= 1'b0;
            name_reg   <= '0;
            argl_reg   <= '0;
            tok_reg    <= '0;
            seen_reg   <= 1'b0;
            err_reg    <= ST_OK;
        end else begin
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            inargs_reg <= inargs_next;
            name_reg   <= name_next;
            argl_reg   <= argl_next;
            tok_reg    <= tok_next;
            seen_reg   <= seen_next;
            err_reg    <= err_next;
        end
    end

    assign argl_commit = argl_reg + tok_reg + {8'd0, argl_reg != 9'd0};
    assign argl_close  = (phase_reg == PH_TOKEN && inargs_reg) ? argl_commit : argl_reg;
    assign arg_base    = argl_reg + {8'd0, argl_reg != 9'd0};
    assign arg_need    = {1'b0, argl_reg} + {1'b0, tok_reg} + 10'd3;
    assign name_need   = {1'b0, name_reg} + 8'd1;

    always_comb begin
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        inargs_next = inargs_reg;
        name_next   = name_reg;
        argl_next   = argl_reg;
        tok_next    = tok_reg;
        seen_next   = seen_reg;
        err_next    = err_reg;
        r0          = '0;
        r1          = '0;
        have0       = 1'b0;
        have1       = 1'b0;
        cnt_after   = cnt_reg;
        line_status = ST_OK;

        if (accept) begin
            if (item.end_of_line) begin
                if (err_reg == ST_OK && phase_reg != PH_START) begin
                    r0 = make_result(KIND_DONE, cnt_reg, argl_close[7:0],
                                     {1'b0, name_reg}, ST_OK);
                    have0 = 1'b0 | 1'b1;
                    cnt_after = cnt_reg + 4'd1;
                end
                if (err_reg != ST_OK) begin
                    line_status = err_reg;
                end else if (cnt_after != 4'd0) begin
                    line_status = ST_OK;
                end else begin
                    line_status = ST_NONE;
                end
                if (have0) begin
                    r1 = make_result(KIND_LINE, cnt_after, 8'd0, 8'd0, line_status);
                    have1 = 1'b1;
                end else begin
                    r0 = make_result(KIND_LINE, cnt_after, 8'd0, 8'd0, line_status);
                    have0 = 1'b1;
                end
                cnt_next    = '0;
                err_next    = ST_OK;
                phase_next  = PH_START;
                inargs_next = 1'b0;
                name_next   = '0;
                argl_next   = '0;
                tok_next    = '0;
                seen_next   = 1'b0;
            end else if (err_reg != ST_OK) begin
                // A latched error swallows every byte until end of line.
            end else if (item.ch == CH_PIPE) begin
                if (phase_reg != PH_START) begin
                    r0 = make_result(KIND_DONE, cnt_reg, argl_close[7:0],
                                     {1'b0, name_reg}, ST_OK);
                    have0 = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                end
                phase_next  = PH_START;
                inargs_next = 1'b0;
                name_next   = '0;
                argl_next   = '0;
                tok_next    = '0;
                seen_next   = 1'b0;
            end else begin
                seen_next = 1'b1;
                if (!seen_reg && cnt_reg >= 4'(MAX_COMMANDS)) begin
                    err_next = ST_TOO_MANY;
                end else if (phase_reg == PH_START) begin
                    if (!is_lead_space(item.ch)) begin
                        r0 = make_result(KIND_NAME, cnt_reg, 8'd0, item.ch, ST_OK);
                        have0 = 1'b1;
                        name_next   = 7'd1;
                        phase_next  = PH_TOKEN;
                        inargs_next = 1'b0;
                    end
                end else if (phase_reg == PH_TOKEN && !inargs_reg) begin
                    if (is_sep(item.ch)) begin
                        inargs_next = 1'b1;
                        phase_next  = PH_GAP;
                        tok_next    = '0;
                    end else if (name_need >= 8'(NAME_BYTES)) begin
                        err_next = ST_TOO_BIG;
                    end else begin
                        r0 = make_result(KIND_NAME, cnt_reg, {1'b0, name_reg},
                                         item.ch, ST_OK);
                        have0 = 1'b1;
                        name_next = name_reg + 7'd1;
                    end
                end else if (is_sep(item.ch)) begin
                    if (phase_reg == PH_TOKEN) begin
                        argl_next = argl_commit;
                        tok_next  = '0;
                    end
                    phase_next = PH_GAP;
                end else if (arg_need >= 10'(ARG_BYTES)) begin
                    err_next = ST_TOO_BIG;
                end else if (phase_reg == PH_GAP) begin
                    // A new argument token starts; its offset within the token is zero.
                    if (argl_reg != 9'd0) begin
                        r0 = make_result(KIND_ARG, cnt_reg, argl_reg[7:0], CH_SPACE, ST_OK);
                        r1 = make_result(KIND_ARG, cnt_reg, arg_base[7:0], item.ch, ST_OK);
                        have0 = 1'b1;
                        have1 = 1'b1;
                    end else begin
                        r0 = make_result(KIND_ARG, cnt_reg, arg_base[7:0], item.ch, ST_OK);
                        have0 = 1'b1;
                    end
                    tok_next   = 9'd1;
                    phase_next = PH_TOKEN;
                end else begin
                    r0 = make_result(KIND_ARG, cnt_reg, 8'(arg_base + tok_reg),
                                     item.ch, ST_OK);
                    have0 = 1'b1;
                    tok_next = tok_reg + 9'd1;
                end
            end
        end

        if (have1) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    assign push         = accept && have0;
    assign entry.first  = r0;
    assign entry.second = r1;
    assign entry.two    = have1;

endmodule
`default_nettype wire

// ===== rtl/clt_back.sv =====
// Back end: result queue that hands out one result per transfer.
`default_nettype none
module clt_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire clt_pkg::entry_t entry,
    output logic                 full,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output clt_pkg::result_t     result
);
    import clt_pkg::*;

    entry_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                sel_reg, sel_next;
    entry_t              head;
    logic                take;
    logic                pop;

    assign head         = queue_reg[rd_ptr_reg];
    assign full         = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign result_valid = count_reg != '0;
    assign result       = sel_reg ? head.second : head.first;
    assign take         = result_valid && !result_stall;
    assign pop          = take && (sel_reg || !head.two);

    always_ff @(posedge clk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (take) begin
            sel_next = !pop;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/command_line_tokenizer.sv =====
// Top level of the command line tokenizer.
//
// The item channel takes one byte of the command line per transfer, closed
// by a transfer with end_of_line set. The result channel returns name and
// argument character writes, a command-done record per command, and a
// line-done record carrying status and command count; last marks the final
// result caused by one input byte.
// The front end takes one byte per cycle while the queue is not full and writes
// that byte's results into a four-entry queue, where they are registered.
// The back end hands out one result per cycle unless the receiver stalls,
// so a byte that produces two results (a joining space plus a character, or
// command done plus line done) occupies two output transfers. Sustained input
// rate is one byte per cycle while the queue has room; item_stall rises when it is full.
// If the receiver stalls, the current result holds and the queue fills.
// Reset empties the queue and returns the scanner to the start of a line
// with no commands counted and no error latched.
`default_nettype none
module command_line_tokenizer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire clt_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output clt_pkg::result_t     result
);
    import clt_pkg::*;

    logic   accept;
    logic   push;
    logic   full;
    entry_t entry;

    assign item_stall = full;
    assign accept     = item_valid && !item_stall;

    clt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .entry  (entry)
    );

    clt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .entry        (entry),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== sim/command_line_tokenizer_tb.sv =====
// Self-checking testbench for the command line tokenizer against a scan-state predictor.
`timescale 1ns / 1ps

module command_line_tokenizer_tb;
    import clt_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    // Tracks the tokenizer's scan state and holds the results still owed by the block.
    class token_scoreboard;
        result_t    expected_results[$];
        result_t    staged[$];
        int         mismatches;
        logic [3:0] cmd_count;
        phase_t     phase;
        bit         in_args;
        bit         seg_seen;
        logic [6:0] name_len;
        logic [8:0] arg_len;
        logic [8:0] tok_len;
        logic [1:0] err;

        function new();
            mismatches = 0;
            cmd_count = '0;
            err = ST_OK;
            clear_segment();
        endfunction

        static function bit gap_char(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF;
        endfunction

        static function bit lead_blank(logic [7:0] c);
            return gap_char(c) || c == CH_VT || c == CH_FF || c == CH_CR;
        endfunction

        function void clear_segment();
            phase = PH_START;
            in_args = 1'b0;
            name_len = '0;
            arg_len = '0;
            tok_len = '0;
            seg_seen = 1'b0;
        endfunction

        function void emit(logic [1:0] kind, logic [3:0] idx, logic [7:0] pos,
                           logic [7:0] chr, logic [1:0] st);
            result_t r;
            r.kind = kind;
            r.cmd_index = idx;
            r.position = pos;
            r.out_char = chr;
            r.status = st;
            r.last = 1'b0;
            staged.push_back(r);
        endfunction

        function void commit_token();
            arg_len = arg_len + tok_len + ((arg_len > 0) ? 9'd1 : 9'd0);
            tok_len = '0;
        endfunction

        function void close_command();
            if (phase != PH_START)
            begin
                if (phase == PH_TOKEN && in_args)
                    commit_token();
                emit(KIND_DONE, cmd_count, arg_len[7:0], {1'b0, name_len}, ST_OK);
                cmd_count = cmd_count + 4'd1;
            end
            clear_segment();
        endfunction

        function void scan_char(logic [7:0] c);
            int base;
            if (!seg_seen)
            begin
                seg_seen = 1'b1;
                // A segment beyond the limit fails even if it turns out to be blank.
                if (cmd_count >= MAX_COMMANDS)
                begin
                    err = ST_TOO_MANY;
                    return;
                end
            end
            if (phase == PH_START)
            begin
                if (!lead_blank(c))
                begin
                    if (1 >= NAME_BYTES)
                        err = ST_TOO_BIG;
                    else
                    begin
                        emit(KIND_NAME, cmd_count, 8'd0, c, ST_OK);
                        name_len = 7'd1;
                        phase = PH_TOKEN;
                        in_args = 1'b0;
                    end
                end
            end
            else if (phase == PH_TOKEN && !in_args)
            begin
                if (gap_char(c))
                begin
                    in_args = 1'b1;
                    phase = PH_GAP;
                    tok_len = '0;
                end
                else if (int'(name_len) + 1 >= NAME_BYTES)
                    err = ST_TOO_BIG;
                else
                begin
                    emit(KIND_NAME, cmd_count, {1'b0, name_len}, c, ST_OK);
                    name_len = name_len + 7'd1;
                end
            end
            else if (gap_char(c))
            begin
                if (phase == PH_TOKEN)
                    commit_token();
                phase = PH_GAP;
            end
            else if (int'(arg_len) + int'(tok_len) + 3 >= ARG_BYTES)
                err = ST_TOO_BIG;
            else
            begin
                base = int'(arg_len) + ((arg_len > 0) ? 1 : 0);
                if (phase == PH_GAP)
                begin
                    // The joining space goes out ahead of the first byte of a later token.
                    if (arg_len > 0)
                        emit(KIND_ARG, cmd_count, arg_len[7:0], CH_SPACE, ST_OK);
                    tok_len = '0;
                    phase = PH_TOKEN;
                end
                emit(KIND_ARG, cmd_count, 8'(base + int'(tok_len)), c, ST_OK);
                tok_len = tok_len + 9'd1;
            end
        endfunction

        // Returns whether the byte was actually scanned rather than dropped after an error.
        function bit note_item(item_t it);
            logic [1:0] st;
            bit scanned;
            staged.delete();
            scanned = it.end_of_line || err == ST_OK;
            if (it.end_of_line)
            begin
                if (err == ST_OK)
                    close_command();
                st = (err != ST_OK) ? err : ((cmd_count > 0) ? ST_OK : ST_NONE);
                emit(KIND_LINE, cmd_count, 8'd0, 8'd0, st);
                cmd_count = '0;
                err = ST_OK;
                clear_segment();
            end
            else if (err != ST_OK)
            begin
            end
            else if (it.ch == CH_PIPE)
                close_command();
            else
                scan_char(it.ch);
            if (staged.size() > 0)
                staged[staged.size() - 1].last = 1'b1;
            foreach (staged[i])
                expected_results.push_back(staged[i]);
            return scanned;
        endfunction

        function void report(string what, result_t want, result_t got);
            string want_text;
            string got_text;
            mismatches++;
            if (mismatches <= 10)
            begin
                want_text = $sformatf("kind=%0d idx=%0d pos=%0d chr=%02h st=%0d last=%0d",
                                      want.kind, want.cmd_index, want.position,
                                      want.out_char, want.status, want.last);
                got_text = $sformatf("kind=%0d idx=%0d pos=%0d chr=%02h st=%0d last=%0d",
                                     got.kind, got.cmd_index, got.position,
                                     got.out_char, got.status, got.last);
                $display("%0t %s: expected %s, got %s", $realtime, what,
                         want_text, got_text);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            string diff;
            if (expected_results.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_results.pop_front();
            diff = "";
            if (got.kind !== want.kind)
                diff = {diff, " kind"};
            if (got.cmd_index !== want.cmd_index)
                diff = {diff, " cmd_index"};
            if (got.position !== want.position)
                diff = {diff, " position"};
            if (got.out_char !== want.out_char)
                diff = {diff, " out_char"};
            if (got.status !== want.status)
                diff = {diff, " status"};
            if (got.last !== want.last)
                diff = {diff, " last"};
            if (diff != "")
                report({"wrong", diff}, want, got);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    token_scoreboard sb = new();
    logic [7:0]  line_text[$];
    int          items_counted = 0;
    int          hold_request = 0;
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    int unsigned cycle_count = 0;

    command_line_tokenizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: checks each transfer and stalls in random bursts or on a long hold.
    initial
    begin : result_side
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
            if (hold_request > 0)
            begin
                burst = hold_request;
                hold_request = 0;
            end
            else if (burst == 0 && recv_idle && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 10);
            if (burst > 0)
            begin
                result_stall <= 1'b1;
                burst--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_word_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 9) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(33, 126));
        end
        while (token_scoreboard::gap_char(c) || c == CH_PIPE);
        return c;
    endfunction

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_gap();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void add_word(int n);
        for (int i = 0; i < n; i++)
            line_text.push_back(pick_word_char());
    endfunction

    function automatic void add_lead(int n);
        for (int i = 0; i < n; i++)
            line_text.push_back(pick_lead());
    endfunction

    function automatic void add_gaps(int n);
        for (int i = 0; i < n; i++)
            line_text.push_back(pick_gap());
    endfunction

    function automatic void add_segment(int name_n, int tokens, int tok_max);
        add_lead($urandom_range(0, 2));
        add_word(name_n);
        for (int i = 0; i < tokens; i++)
        begin
            add_gaps($urandom_range(1, 3));
            add_word($urandom_range(1, tok_max));
        end
        add_gaps($urandom_range(0, 2));
    endfunction

    function automatic void build_normal(int segments);
        for (int s = 0; s < segments; s++)
        begin
            if (s > 0)
            begin
                line_text.push_back(CH_PIPE);
                case ($urandom_range(0, 5))
                    0: line_text.push_back(CH_PIPE);
                    1:
                    begin
                        add_lead($urandom_range(1, 3));
                        line_text.push_back(CH_PIPE);
                    end
                    default: ;
                endcase
            end
            add_segment($urandom_range(1, 8), $urandom_range(0, 4), 6);
        end
        if ($urandom_range(0, 4) == 0)
            line_text.push_back(CH_PIPE);
    endfunction

    function automatic void build_line();
        int pick;
        int segments;
        int total;
        int w;
        int target;
        line_text.delete();
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            segments = ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_COMMANDS)
                                                   : $urandom_range(1, 4);
            build_normal(segments);
        end
        else if (pick < 72)
        begin
            segments = $urandom_range(MAX_COMMANDS + 1, MAX_COMMANDS + 3);
            for (int s = 0; s < segments; s++)
            begin
                if (s > 0)
                    line_text.push_back(CH_PIPE);
                if (s == MAX_COMMANDS && $urandom_range(0, 1) == 0)
                    add_lead($urandom_range(1, 3));
                else
                    add_segment($urandom_range(1, 3), $urandom_range(0, 1), 3);
            end
        end
        else if (pick < 80)
        begin
            add_lead($urandom_range(0, 1));
            add_word($urandom_range(NAME_BYTES - 4, NAME_BYTES + 2));
            if ($urandom_range(0, 1) == 0)
            begin
                add_gaps(1);
                add_word($urandom_range(1, 5));
            end
            if ($urandom_range(0, 1) == 0)
                build_normal(1);
        end
        else if (pick < 86)
        begin
            // Argument string built to end close to the length limit.
            add_word(2);
            total = 0;
            target = $urandom_range(ARG_BYTES - 16, ARG_BYTES + 6);
            while (total < target)
            begin
                if (total > 0)
                begin
                    add_gaps($urandom_range(1, 2));
                    total++;
                end
                w = $urandom_range(10, 40);
                add_word(w);
                total += w;
            end
        end
        else
        begin
            w = $urandom_range(1, 24);
            for (int i = 0; i < w; i++)
            begin
                case ($urandom_range(0, 3))
                    0: line_text.push_back(CH_PIPE);
                    1: line_text.push_back(pick_lead());
                    default: line_text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit eol);
        item_t it;
        it.ch = c;
        it.end_of_line = eol;
        if (send_idle && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (sb.note_item(it))
            items_counted++;
    endtask

    task automatic send_line();
        foreach (line_text[i])
            send_byte(line_text[i], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit quiet;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty line, then a leading pipe, a blank segment, a name with a zero byte,
        // joined arguments, a high byte, and leading space, VT, CR and FF blanks.
        line_text.delete();
        send_line();
        line_text = '{CH_PIPE, CH_SPACE, CH_VT, CH_PIPE, "x", 8'h00, CH_SPACE, CH_SPACE,
                      "a", CH_SPACE, "b", 8'hFF, CH_TAB, CH_PIPE, CH_CR, CH_FF, "q",
                      CH_LF, "r"};
        send_line();
        wait_drain();

        // Long receiver hold while bytes keep coming, so the output queue fills up.
        hold_request = 80;
        line_text.delete();
        build_normal(4);
        send_line();
        wait_drain();

        while (items_counted < ITEM_TARGET)
        begin
            quiet = items_counted >= ITEM_TARGET * 7 / 8;
            send_idle = !quiet && $urandom_range(0, 3) != 0;
            recv_idle = !quiet && $urandom_range(0, 3) != 0;
            build_line();
            send_line();
            if (!quiet && $urandom_range(0, 15) == 0)
                wait_drain();
        end
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.expected_results.size() != 0)
            $display("%0d expected results never arrived", sb.expected_results.size());
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
